@@ design/dtq_pkg.sv @@
// Shared types and constants for the deadline timer queue.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ID_W   = 4;
  localparam int DL_W   = 63;
  localparam int ST_W   = 2;

  typedef logic [SLOTS-1:0]  slot_mask_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [DL_W-1:0]   dl_t;

  typedef enum logic [2:0] {
    ACT_SUBMIT     = 3'd0,
    ACT_CANCEL     = 3'd1,
    ACT_ABORT      = 3'd2,
    ACT_CANCEL_ALL = 3'd3,
    ACT_FIRE       = 3'd4,
    ACT_SHUTDOWN   = 3'd5
  } action_t;

  localparam logic [ST_W-1:0] ST_EXPIRED   = 2'd0;
  localparam logic [ST_W-1:0] ST_CANCELLED = 2'd1;
  localparam logic [ST_W-1:0] ST_ABORTED   = 2'd2;

  // Request to the scan unit. The select mask, mode and time are held
  // stable by the controller for the whole pass.
  typedef struct packed {
    logic       go;
    logic       fire;
    slot_mask_t sel;
    dl_t        now;
  } scan_cmd_t;

  typedef struct packed {
    logic       done;
    slot_t      best_id;
    slot_mask_t due;
    logic       rem_any;
    dl_t        rem_min;
  } scan_res_t;

endpackage

`default_nettype wire

@@ design/dtq_ram.sv @@
// Deadline storage: one entry per slot, one write port, one registered read port.
// Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtq_ram (
  input  logic          clk,
  input  logic          we,
  input  dtq_pkg::slot_t wr_addr,
  input  dtq_pkg::dl_t   wr_data,
  input  dtq_pkg::slot_t rd_addr,
  output dtq_pkg::dl_t   rd_data
);
  import dtq_pkg::*;

  dl_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/dtq_scan.sv @@
// Scan unit: walks every slot of the deadline memory once per pass with one
// comparator path. Depends on dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtq_scan (
  input  logic               clk,
  input  logic               rst,
  input  dtq_pkg::scan_cmd_t cmd,
  output dtq_pkg::slot_t     rd_addr,
  input  dtq_pkg::dl_t       rd_data,
  output dtq_pkg::scan_res_t res
);
  import dtq_pkg::*;

  localparam slot_t LAST = SLOT_W'(SLOTS - 1);

  logic       running;
  slot_t      cnt;
  logic       rd_vld;
  slot_t      rd_idx;
  logic       done;
  logic       best_any;
  slot_t      best_id;
  dl_t        best_val;
  slot_mask_t due;
  logic       rem_any;
  dl_t        rem_min;
  logic       hit;

  assign rd_addr = cnt;
  assign hit     = rd_vld && cmd.sel[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      done   <= rd_vld && (rd_idx == LAST);
      rd_vld <= running;
      if (cmd.go) begin
        running <= 1'b1;
      end else if (running && cnt == LAST) begin
        running <= 1'b0;
      end
    end
  end

  // In fire mode the pass sorts pending slots into due and remaining and
  // keeps the earliest remaining deadline; otherwise it looks for the
  // earliest selected slot. Ascending order with a strict compare leaves
  // the lower slot in place on equal deadlines.
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (cmd.go) begin
      cnt      <= '0;
      best_any <= 1'b0;
      rem_any  <= 1'b0;
      due      <= '0;
    end else begin
      if (running) begin
        cnt <= cnt + 1'b1;
      end
      if (hit) begin
        if (cmd.fire) begin
          if (rd_data <= cmd.now) begin
            due[rd_idx] <= 1'b1;
          end else if (!rem_any || rd_data < rem_min) begin
            rem_any <= 1'b1;
            rem_min <= rd_data;
          end
        end else if (!best_any || rd_data < best_val) begin
          best_any <= 1'b1;
          best_val <= rd_data;
          best_id  <= rd_idx;
        end
      end
    end
  end

  assign res.done    = done;
  assign res.best_id = best_id;
  assign res.due     = due;
  assign res.rem_any = rem_any;
  assign res.rem_min = rem_min;

endmodule

`default_nettype wire

@@ design/deadline_timer_queue_top.sv @@
// Top level of the deadline timer queue: command decode, pending and armed state.
// Depends on dtq_pkg, dtq_ram and dtq_scan.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is accepted on a rising edge where start is high and busy is
// low. Results come out one per cycle-long pulse of done, with done_id,
// status, last, next_deadline and timer_armed valid in that cycle; the
// receiver cannot stall them, so it must take every pulse. Submit, cancel one
// and abort one finish without a scan and their result, if any, appears in
// the following cycle. Timer fire, cancel all and shutdown work through the
// deadline memory with one scan unit: each pass reads every slot once through
// the single read port. Cancel all and shutdown need one pass per removed
// wait; timer fire needs one pass to find the due waits and the new armed
// deadline, then one pass per expired wait, and busy stays high until the
// last pass is through. Results of one transaction come in deadline order,
// lower slot first on equal deadlines, and the final one carries last.
// next_deadline and timer_armed give the armed state after the whole
// transaction; next_deadline reads zero when unarmed. The deadline memory is
// only written by submit while idle and only read by scans while busy, so
// its accesses never overlap.

module deadline_timer_queue_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic [dtq_pkg::ID_W-1:0]  wait_id,
  input  logic [dtq_pkg::DL_W-1:0]  deadline,
  input  logic [dtq_pkg::DL_W-1:0]  now_time,
  output logic                      done,
  output logic [dtq_pkg::ID_W-1:0]  done_id,
  output logic [dtq_pkg::ST_W-1:0]  status,
  output logic                      last,
  output logic [dtq_pkg::DL_W-1:0]  next_deadline,
  output logic                      timer_armed
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PREP  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t          state;
  slot_mask_t      pending;
  logic            armed;
  dl_t             armed_dl;
  logic            shut;
  slot_mask_t      sel;
  dl_t             now_q;
  logic            fire_q;
  logic            go;
  logic [ST_W-1:0] status_q;

  logic       accept;
  action_t    act;
  logic       id_ok;
  slot_t      slot_idx;
  slot_mask_t slot_bit;
  slot_mask_t best_bit;
  slot_mask_t sel_left;
  logic       mem_we;
  slot_t      rd_addr;
  dl_t        rd_data;
  scan_cmd_t  scmd;
  scan_res_t  sres;
  logic       rearm;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign act      = action_t'(action);
  assign id_ok    = (32'(wait_id) < SLOTS);
  assign slot_idx = SLOT_W'(wait_id);
  assign slot_bit = slot_mask_t'(1) << slot_idx;
  assign best_bit = slot_mask_t'(1) << sres.best_id;
  assign sel_left = sel & ~best_bit;
  assign rearm    = sres.rem_any && !shut;

  assign mem_we = accept && (act == ACT_SUBMIT) && id_ok && !shut;

  assign scmd.go   = go;
  assign scmd.fire = fire_q;
  assign scmd.sel  = sel;
  assign scmd.now  = now_q;

  assign next_deadline = armed ? armed_dl : '0;
  assign timer_armed   = armed;

  dtq_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (slot_idx),
    .wr_data (deadline),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dtq_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .cmd     (scmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pending  <= '0;
      armed    <= 1'b0;
      armed_dl <= '0;
      shut     <= 1'b0;
      go       <= 1'b0;
      done     <= 1'b0;
    end else begin
      go   <= 1'b0;
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (act)
              ACT_SUBMIT: begin
                if (id_ok) begin
                  if (shut) begin
                    // After shutdown a submit is cancelled on the spot.
                    done    <= 1'b1;
                    done_id <= wait_id;
                    status  <= ST_CANCELLED;
                    last    <= 1'b1;
                  end else begin
                    pending <= pending | slot_bit;
                    if (!armed || deadline < armed_dl) begin
                      armed    <= 1'b1;
                      armed_dl <= deadline;
                    end
                  end
                end
              end
              ACT_CANCEL, ACT_ABORT: begin
                if (id_ok && pending[slot_idx]) begin
                  pending <= pending & ~slot_bit;
                  done    <= 1'b1;
                  done_id <= wait_id;
                  status  <= (act == ACT_CANCEL) ? ST_CANCELLED : ST_ABORTED;
                  last    <= 1'b1;
                  if ((pending & ~slot_bit) == '0) begin
                    armed    <= 1'b0;
                    armed_dl <= '0;
                  end
                end
              end
              ACT_CANCEL_ALL: begin
                armed    <= 1'b0;
                armed_dl <= '0;
                if (pending != '0) begin
                  sel      <= pending;
                  fire_q   <= 1'b0;
                  go       <= 1'b1;
                  status_q <= ST_CANCELLED;
                  state    <= S_DRAIN;
                end
              end
              ACT_FIRE: begin
                sel    <= pending;
                now_q  <= now_time;
                fire_q <= 1'b1;
                go     <= 1'b1;
                state  <= S_PREP;
              end
              ACT_SHUTDOWN: begin
                if (!shut) begin
                  shut     <= 1'b1;
                  armed    <= 1'b0;
                  armed_dl <= '0;
                  if (pending != '0) begin
                    sel      <= pending;
                    fire_q   <= 1'b0;
                    go       <= 1'b1;
                    status_q <= ST_CANCELLED;
                    state    <= S_DRAIN;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PREP: begin
          // The first pass of a timer fire settles the new armed deadline
          // before any expired wait is reported.
          if (sres.done) begin
            armed    <= rearm;
            armed_dl <= rearm ? sres.rem_min : '0;
            if (sres.due != '0) begin
              sel      <= sres.due;
              fire_q   <= 1'b0;
              go       <= 1'b1;
              status_q <= ST_EXPIRED;
              state    <= S_DRAIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DRAIN: begin
          if (sres.done) begin
            done    <= 1'b1;
            done_id <= ID_W'(sres.best_id);
            status  <= status_q;
            last    <= (sel_left == '0);
            sel     <= sel_left;
            pending <= pending & ~best_bit;
            if (sel_left != '0) begin
              go <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ dv/deadline_timer_queue_checker.sv @@
// Checker for the deadline timer queue: watches the command and completion channels.
// Predicts each completion from its own copy of the queue state; depends on dtq_pkg.
`timescale 1ns / 1ps

module deadline_timer_queue_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [2:0]               action,
  input  logic [dtq_pkg::ID_W-1:0] wait_id,
  input  logic [dtq_pkg::DL_W-1:0] deadline,
  input  logic [dtq_pkg::DL_W-1:0] now_time,
  input  logic                     done,
  input  logic [dtq_pkg::ID_W-1:0] done_id,
  input  logic [dtq_pkg::ST_W-1:0] status,
  input  logic                     last,
  input  logic [dtq_pkg::DL_W-1:0] next_deadline,
  input  logic                     timer_armed,
  output int                       mismatches,
  output int                       completions_due,
  output dtq_pkg::slot_mask_t      pending_slots
);

  import dtq_pkg::*;

  typedef struct {
    logic [ID_W-1:0] slot;
    logic [ST_W-1:0] st;
    logic            closes;
    dl_t             next_dl;
    logic            armed;
  } completion_t;

  dl_t         slot_deadline [SLOTS];
  slot_mask_t  pending;
  dl_t         armed_at;
  logic        armed_now;
  logic        shut_down;
  int unsigned drain_order [$];
  completion_t completion_q [$];
  int          fail_total;

  // Pending slot in sel with the smallest deadline, the lower slot on a tie.
  function automatic int earliest_slot(slot_mask_t sel);
    int best;
    bit found;
    best = 0;
    found = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (sel[s] && (!found || slot_deadline[s] < slot_deadline[best])) begin
        best = s;
        found = 1'b1;
      end
    end
    return best;
  endfunction

  task automatic drain_in_order(slot_mask_t sel);
    int s;
    while (sel != '0) begin
      s = earliest_slot(sel);
      drain_order.push_back(unsigned'(s));
      sel[s] = 1'b0;
      pending[s] = 1'b0;
    end
  endtask

  task automatic predict_completions(logic [2:0] act, logic [ID_W-1:0] id, dl_t dl, dl_t now);
    slot_mask_t      due;
    logic [ST_W-1:0] st;
    completion_t     c;
    bit              id_ok;
    id_ok = int'(id) < SLOTS;
    st = ST_CANCELLED;
    due = '0;
    drain_order.delete();
    case (act)
      ACT_SUBMIT: begin
        if (id_ok && shut_down) begin
          drain_order.push_back(32'(id));
        end else if (id_ok) begin
          slot_deadline[id] = dl;
          pending[id] = 1'b1;
          // A submit only ever pulls the armed deadline in, never out.
          if (!armed_now || dl < armed_at) begin
            armed_at = dl;
            armed_now = 1'b1;
          end
        end
      end
      ACT_CANCEL, ACT_ABORT: begin
        if (id_ok && pending[id]) begin
          pending[id] = 1'b0;
          drain_order.push_back(32'(id));
          st = (act == ACT_CANCEL) ? ST_CANCELLED : ST_ABORTED;
        end
      end
      ACT_CANCEL_ALL: drain_in_order(pending);
      ACT_FIRE: begin
        for (int s = 0; s < SLOTS; s++) due[s] = pending[s] && slot_deadline[s] <= now;
        drain_in_order(due);
        st = ST_EXPIRED;
        if (pending != '0 && !shut_down) begin
          armed_at = slot_deadline[earliest_slot(pending)];
          armed_now = 1'b1;
        end else begin
          armed_at = '0;
          armed_now = 1'b0;
        end
      end
      ACT_SHUTDOWN: begin
        if (!shut_down) begin
          shut_down = 1'b1;
          drain_in_order(pending);
          armed_at = '0;
          armed_now = 1'b0;
        end
      end
      default: ;
    endcase
    // An empty queue always leaves the timer disarmed.
    if (pending == '0) begin
      armed_at = '0;
      armed_now = 1'b0;
    end
    foreach (drain_order[k]) begin
      c.slot = ID_W'(drain_order[k]);
      c.st = st;
      c.closes = (k == drain_order.size() - 1);
      c.next_dl = armed_now ? armed_at : '0;
      c.armed = armed_now;
      completion_q.push_back(c);
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_completion();
    completion_t want;
    if (completion_q.size() == 0) begin
      $display("%0t: unexpected completion, slot %0d status %0d last %0d",
               $time, done_id, status, last);
      fail_total++;
    end else begin
      want = completion_q.pop_front();
      compare_field("done_id", 64'(want.slot), 64'(done_id));
      compare_field("status", 64'(want.st), 64'(status));
      compare_field("last", 64'(want.closes), 64'(last));
      compare_field("next_deadline", 64'(want.next_dl), 64'(next_deadline));
      compare_field("timer_armed", 64'(want.armed), 64'(timer_armed));
    end
  endtask

  // Results are checked before the transaction taken at the same edge is
  // predicted; a result can never belong to a transaction accepted at its edge.
  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_deadline[s]) slot_deadline[s] = '0;
      pending = '0;
      armed_at = '0;
      armed_now = 1'b0;
      shut_down = 1'b0;
      completion_q.delete();
      fail_total = 0;
    end else begin
      if (done) check_completion();
      if (start && !busy) predict_completions(action, wait_id, deadline, now_time);
    end
    mismatches <= fail_total;
    completions_due <= completion_q.size();
    pending_slots <= pending;
  end

endmodule

@@ dv/deadline_timer_queue_top_test.sv @@
// Testbench top for the deadline timer queue: clock, reset, stimulus and verdict.
// Depends on dtq_pkg, deadline_timer_queue_top and deadline_timer_queue_checker.
`timescale 1ns / 1ps

module deadline_timer_queue_top_test;

  import dtq_pkg::*;

  // Action codes the block has no use for; it must ignore them.
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  localparam dl_t DL_MAX       = '1;
  localparam int  ID_MAX       = (1 << ID_W) - 1;
  localparam int  RANDOM_ITEMS = 285;
  // One scan pass over the deadline memory.
  localparam int  SCAN_CYCLES  = SLOTS + 3;
  // Four times the slowest correct transaction: a full drain, one pass per slot plus one.
  localparam int  DRAIN_LIMIT  = 4 * (SLOTS + 1) * SCAN_CYCLES;
  // About 310 transactions of at most 17 passes each, plus random gaps, set the
  // run time; the limit leaves a wide margin over that.
  localparam int  CYCLE_LIMIT  = 600000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          action = 3'd0;
  logic [ID_W-1:0]     wait_id = '0;
  dl_t                 deadline = '0;
  dl_t                 now_time = '0;
  logic                done;
  logic [ID_W-1:0]     done_id;
  logic [ST_W-1:0]     status;
  logic                last;
  dl_t                 next_deadline;
  logic                timer_armed;

  int                  mismatches;
  int                  completions_due;
  slot_mask_t          pending_slots;

  // Notional wall clock that fire transactions move forward, so that most
  // deadlines land close enough to expire within a few fires.
  dl_t                 wall_ns = 63'd1000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  deadline_timer_queue_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .wait_id       (wait_id),
    .deadline      (deadline),
    .now_time      (now_time),
    .done          (done),
    .done_id       (done_id),
    .status        (status),
    .last          (last),
    .next_deadline (next_deadline),
    .timer_armed   (timer_armed)
  );

  deadline_timer_queue_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .wait_id         (wait_id),
    .deadline        (deadline),
    .now_time        (now_time),
    .done            (done),
    .done_id         (done_id),
    .status          (status),
    .last            (last),
    .next_deadline   (next_deadline),
    .timer_armed     (timer_armed),
    .mismatches      (mismatches),
    .completions_due (completions_due),
    .pending_slots   (pending_slots)
  );

  // Presents one transaction and returns at the edge that accepts it. Start
  // is left high, so a following transaction goes out back to back.
  task automatic issue(logic [2:0] act, logic [ID_W-1:0] id, dl_t dl, dl_t now);
    start <= 1'b1;
    action <= act;
    wait_id <= id;
    deadline <= dl;
    now_time <= now;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Deadlines are mostly near the wall clock, with a share of ties, the
  // extremes and fully random values so that every bit toggles.
  function automatic dl_t pick_deadline();
    int unsigned roll;
    dl_t         wide;
    roll = $urandom_range(0, 99);
    wide = dl_t'({$urandom, $urandom});
    if (roll < 6) return '0;
    else if (roll < 12) return DL_MAX;
    else if (roll < 22) return wide;
    else if (roll < 42) return wall_ns + dl_t'(100 * $urandom_range(0, 3));
    else return wall_ns + dl_t'($urandom_range(0, 1500));
  endfunction

  function automatic dl_t pick_now();
    int unsigned roll;
    dl_t         wide;
    roll = $urandom_range(0, 99);
    wide = dl_t'({$urandom, $urandom});
    if (roll < 4) return '0;
    else if (roll < 8) return DL_MAX;
    else if (roll < 14) return wide;
    else return wall_ns;
  endfunction

  // Cancel and abort mostly aim at a slot that is pending, so that they do
  // real work; the rest hit any slot. The mask seen here lags by at most one
  // transaction, which only blurs the aim.
  function automatic logic [ID_W-1:0] pick_victim();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, ID_MAX));
    if (pending_slots != '0 && $urandom_range(0, 3) != 0) begin
      for (int n = 0; n < 64 && !pending_slots[id]; n++) begin
        id = ID_W'($urandom_range(0, ID_MAX));
      end
    end
    return id;
  endfunction

  // One random transaction. Shutdown is kept out of the random part, since it
  // is permanent and would leave nothing but immediate cancels behind it.
  // Counted is low for a transaction that the block simply ignores.
  task automatic random_item(output bit counted);
    int unsigned     roll;
    logic [2:0]      act;
    logic [ID_W-1:0] id;
    dl_t             dl;
    dl_t             now;
    roll = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, ID_MAX));
    dl = pick_deadline();
    now = dl_t'({$urandom, $urandom});
    if (roll < 50) begin
      act = ACT_SUBMIT;
    end else if (roll < 70) begin
      act = ACT_FIRE;
      wall_ns += dl_t'($urandom_range(0, 700));
      now = pick_now();
    end else if (roll < 84) begin
      act = ACT_CANCEL;
      id = pick_victim();
    end else if (roll < 94) begin
      act = ACT_ABORT;
      id = pick_victim();
    end else if (roll < 97) begin
      act = ACT_CANCEL_ALL;
    end else if (roll < 99) begin
      act = ACT_RSVD_6;
    end else begin
      act = ACT_RSVD_7;
    end
    counted = !(act == ACT_RSVD_6 || act == ACT_RSVD_7) &&
              !((act == ACT_CANCEL || act == ACT_ABORT) && !pending_slots[id]);
    issue(act, id, dl, now);
  endtask

  initial begin
    int counted_items;
    int burst;
    bit counted;
    int waited;
    bit leftover;
    counted_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The queue starts empty: a fire with nothing armed and a
    // cancel of an idle slot must both pass without a result.
    issue(ACT_FIRE, 4'd0, '0, 63'd500);
    issue(ACT_CANCEL, 4'd0, '0, '0);
    // Arm at 200, then resubmit the same slot later: the deadline is replaced
    // but the armed deadline must not move out.
    issue(ACT_SUBMIT, 4'd3, 63'd200, '0);
    issue(ACT_SUBMIT, 4'd3, 63'd900, '0);
    // Two equal deadlines, the largest deadline, and the smallest one.
    issue(ACT_SUBMIT, 4'd10, 63'd400, '0);
    issue(ACT_SUBMIT, 4'd12, 63'd400, '0);
    issue(ACT_SUBMIT, 4'd0, DL_MAX, '0);
    issue(ACT_SUBMIT, 4'd15, '0, '0);
    idle(3);
    // Fire expires slot 15 alone, then the tie, lower slot first.
    issue(ACT_FIRE, 4'd0, '0, 63'd100);
    issue(ACT_FIRE, 4'd0, '0, 63'd400);
    // Abort a pending slot, then the same slot again with nothing to abort.
    issue(ACT_ABORT, 4'd3, '0, '0);
    issue(ACT_ABORT, 4'd3, '0, '0);
    issue(ACT_RSVD_6, 4'd5, DL_MAX, DL_MAX);
    issue(ACT_RSVD_7, 4'd9, '0, '0);
    issue(ACT_SUBMIT, 4'd9, 63'd7, '0);
    issue(ACT_CANCEL, 4'd9, '0, '0);
    // Fire at the largest time expires the largest deadline and disarms.
    issue(ACT_FIRE, 4'd0, '0, DL_MAX);
    issue(ACT_SUBMIT, 4'd1, 63'd10, '0);
    issue(ACT_SUBMIT, 4'd2, 63'd10, '0);
    issue(ACT_SUBMIT, 4'd4, 63'd5, '0);
    issue(ACT_CANCEL_ALL, 4'd0, '0, '0);
    idle(2);

    // Random part: bursts of random length with random gaps between them, and
    // now and then a long burst with no gap at all. The gaps start at the
    // acceptance edge, so they land on every phase of the scans in progress.
    burst = $urandom_range(1, 24);
    while (counted_items < RANDOM_ITEMS) begin
      random_item(counted);
      counted_items += int'(counted);
      burst--;
      if (burst == 0) begin
        idle($urandom_range(1, 15));
        burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
      end
    end

    // Shutdown with waits pending, a repeated shutdown, then a submit that is
    // cancelled at once and commands that find the queue empty.
    issue(ACT_SUBMIT, 4'd6, 63'd1234, '0);
    issue(ACT_SUBMIT, 4'd8, 63'd99, '0);
    issue(ACT_SHUTDOWN, 4'd0, '0, '0);
    issue(ACT_SHUTDOWN, 4'd0, '0, '0);
    issue(ACT_SUBMIT, 4'd7, 63'd50, '0);
    issue(ACT_FIRE, 4'd0, '0, DL_MAX);
    issue(ACT_CANCEL_ALL, 4'd0, '0, '0);
    start <= 1'b0;

    // Wait for every predicted completion, then a quiet stretch in which any
    // stray result would still be caught by the checker.
    @(posedge clk);
    waited = 0;
    while (completions_due != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    leftover = (completions_due != 0);
    if (leftover) $display("%0t: %0d completions never arrived", $time, completions_due);
    repeat (2 * SCAN_CYCLES) @(posedge clk);
    if (mismatches == 0 && !leftover) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a transaction that is never accepted or never finishes.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
